// ===== hdl/command_frame_checker_core_defines.svh =====
// Assertion helpers used by the frame tracker RTL.
`ifndef COMMAND_FRAME_CHECKER_CORE_DEFINES_SVH
`define COMMAND_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cfc_pkg.sv =====
package cfc_pkg;

   // Frame layout positions, counted from zero
   localparam logic [15:0] LEN_HI_POS    = 16'd2;
   localparam logic [15:0] LEN_LO_POS    = 16'd3;
   localparam logic [15:0] FORMAT_POS    = 16'd4;
   localparam logic [15:0] ID_FIRST      = 16'd5;
   localparam int unsigned ID_BYTES      = 8;
   localparam logic [15:0] ID_LAST       = ID_FIRST + 16'(ID_BYTES - 1);
   localparam logic [15:0] FUNC_POS      = 16'd13;
   localparam logic [15:0] ARG_FIRST     = FUNC_POS + 16'd1;
   localparam logic [16:0] MIN_FRAME_LEN = 17'd15;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   localparam logic KIND_ARG    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  arg_byte;
      logic [15:0] arg_index;
      logic [1:0]  frame_status;
      logic [7:0]  fmt_byte;
      logic [7:0]  cmd_byte;
      logic [15:0] frame_length;
      logic        id_match;
   } rsp_type;

   // One processed byte: whether it yields a response, and that response
   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_type;

endpackage

// ===== hdl/cfc_frame_tracker.sv =====
`include "command_frame_checker_core_defines.svh"

module cfc_frame_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              process,
   input  cfc_pkg::req_type  req,
   input  logic [63:0]       own_device_id,
   output cfc_pkg::step_type step
);
   import cfc_pkg::*;

   logic [15:0] byte_count_ff,      byte_count_in;
   logic [7:0]  running_sum_ff,     running_sum_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [7:0]  format_byte_ff,     format_byte_in;
   logic [7:0]  command_code_ff,    command_code_in;
   logic        identity_ok_ff,     identity_ok_in;
   logic        count_overflow_ff,  count_overflow_in;

   logic [2:0]  id_sel;
   logic [5:0]  id_lsb;
   logic [7:0]  id_want;
   logic [16:0] actual_len;

   // Identity byte 5 sits in bits 63:56, byte 12 in bits 7:0
   assign id_sel     = 3'(byte_count_ff - ID_FIRST);
   assign id_lsb     = {~id_sel, 3'b000};
   assign id_want    = own_device_id[id_lsb +: 8];
   assign actual_len = {1'b0, byte_count_ff} + 17'd1;

   always_comb begin
      byte_count_in      = byte_count_ff;
      running_sum_in     = running_sum_ff;
      declared_length_in = declared_length_ff;
      format_byte_in     = format_byte_ff;
      command_code_in    = command_code_ff;
      identity_ok_in     = identity_ok_ff;
      count_overflow_in  = count_overflow_ff;
      step               = '0;

      if (req.last_byte) begin
         step.emit              = 1'b1;
         step.rsp.item_kind     = KIND_STATUS;
         step.rsp.fmt_byte      = format_byte_ff;
         step.rsp.cmd_byte      = command_code_ff;
         step.rsp.frame_length  = declared_length_ff;
         step.rsp.id_match      = identity_ok_ff;
         if (count_overflow_ff || (actual_len < MIN_FRAME_LEN) ||
             (actual_len != {1'b0, declared_length_ff})) begin
            step.rsp.frame_status = STATUS_LENGTH;
         end else if (running_sum_ff != req.rx_byte) begin
            step.rsp.frame_status = STATUS_CHECKSUM;
         end else begin
            step.rsp.frame_status = STATUS_OK;
         end
         byte_count_in      = '0;
         running_sum_in     = '0;
         declared_length_in = '0;
         format_byte_in     = '0;
         command_code_in    = '0;
         identity_ok_in     = 1'b1;
         count_overflow_in  = 1'b0;
      end else if (!count_overflow_ff) begin
         running_sum_in = running_sum_ff + req.rx_byte;
         unique case (byte_count_ff) inside
            LEN_HI_POS: begin
               declared_length_in[15:8] = req.rx_byte;
            end
            LEN_LO_POS: begin
               declared_length_in[7:0] = req.rx_byte;
            end
            FORMAT_POS: begin
               format_byte_in = req.rx_byte;
            end
            [ID_FIRST:ID_LAST]: begin
               if (id_want != req.rx_byte) begin
                  identity_ok_in = 1'b0;
               end
            end
            FUNC_POS: begin
               command_code_in = req.rx_byte;
            end
            default: begin
            end
         endcase

         if (byte_count_ff == COUNT_MAX) begin
            count_overflow_in = 1'b1;
         end else begin
            byte_count_in = byte_count_ff + 16'd1;
         end

         if (byte_count_ff > FUNC_POS) begin
            step.emit          = 1'b1;
            step.rsp.item_kind = KIND_ARG;
            step.rsp.arg_byte  = req.rx_byte;
            step.rsp.arg_index = byte_count_ff - ARG_FIRST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         running_sum_ff     <= '0;
         declared_length_ff <= '0;
         format_byte_ff     <= '0;
         command_code_ff    <= '0;
         identity_ok_ff     <= 1'b1;
         count_overflow_ff  <= 1'b0;
      end else if (process) begin
         byte_count_ff      <= byte_count_in;
         running_sum_ff     <= running_sum_in;
         declared_length_ff <= declared_length_in;
         format_byte_ff     <= format_byte_in;
         command_code_ff    <= command_code_in;
         identity_ok_ff     <= identity_ok_in;
         count_overflow_ff  <= count_overflow_in;
      end
   end

   `CFC_ASSERT_NEXT(a_last_clears, clock, reset, process && req.last_byte, (byte_count_ff == '0) && identity_ok_ff && !count_overflow_ff, "frame state not cleared after last byte")
   `CFC_ASSERT_NEXT(a_sat_holds, clock, reset, process && !req.last_byte && count_overflow_ff, $stable(byte_count_ff) && $stable(running_sum_ff), "saturated frame state changed")
   `CFC_ASSERT_NOW(a_arg_pos, clock, reset, step.emit && !req.last_byte, (byte_count_ff > FUNC_POS) && !count_overflow_ff, "argument emitted outside argument area")

endmodule

// ===== hdl/cfc_rsp_stage.sv =====
module cfc_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cfc_pkg::rsp_type load_data,
   output logic             ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfc_pkg::rsp_type rsp_data
);
   import cfc_pkg::*;

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   // Free when empty or when the held response leaves this cycle
   assign ready  = !vld_ff || !rsp_stall;
   assign vld_in = load ? 1'b1 : (ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/command_frame_checker_core.sv =====
// Path: a request waits in the input register, then its response in the response register.
// Throughput: one request per cycle; the input register and response register are each
//   one slot, so a stalled response holds one request back and then stalls req.
// Reset (synchronous, active high): empties both slots, clears the frame state and
//   sets the device ID register to zero.
module command_frame_checker_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [63:0]      csr_wr_data
);
   import cfc_pkg::*;

   // Input register: one request waiting for the frame tracker
   logic     in_vld_ff, in_vld_in;
   req_type  in_data_ff;

   // Configured device identity
   logic [63:0] own_id_ff;

   logic     rsp_ready;
   logic     process;
   logic     accept;
   step_type step;

   // The tracker consumes the held request whenever the response slot can take
   // a result this cycle. Requests that produce nothing still wait for it,
   // which keeps the control path short.
   assign process   = in_vld_ff && rsp_ready;
   assign req_stall = in_vld_ff && !process;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept ? 1'b1 : (process ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   // Must be written only while idle; the block does not enforce this. No read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_wr_en) begin
         own_id_ff <= csr_wr_data;
      end
   end

   // Per-byte frame state: length, format and command capture, identity compare, checksum, arg index
   cfc_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .process       (process),
      .req           (in_data_ff),
      .own_device_id (own_id_ff),
      .step          (step)
   );

   // Response register toward the consumer
   cfc_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (process && step.emit),
      .load_data (step.rsp),
      .ready     (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import cfc_pkg::*;

   // Run shape
   localparam int PHASE_ITEMS     = 430;     // random requests per ID setting
   localparam int DRAIN_CYCLES    = 4;       // pipeline is two deep; margin on top
   localparam int TAIL_CYCLES     = 16;
   localparam int HOLDOFF_AFTER   = 300;     // responses seen before the long receiver stall
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT  = 4000;    // cycles with no handshake on either side

   // Hand-read responses for the directed table
   localparam rsp_type SHORT_AFTER_RESET = '{item_kind: KIND_STATUS, arg_byte: 8'h00,
      arg_index: 16'h0000, frame_status: STATUS_LENGTH, fmt_byte: 8'h00,
      cmd_byte: 8'h00, frame_length: 16'h0000, id_match: 1'b1};
   localparam rsp_type FIRST_ARG_FF = '{item_kind: KIND_ARG, arg_byte: 8'hFF,
      arg_index: 16'h0000, frame_status: STATUS_OK, fmt_byte: 8'h00,
      cmd_byte: 8'h00, frame_length: 16'h0000, id_match: 1'b0};
   localparam rsp_type GOOD_FRAME_16 = '{item_kind: KIND_STATUS, arg_byte: 8'h00,
      arg_index: 16'h0000, frame_status: STATUS_OK, fmt_byte: 8'hFF,
      cmd_byte: 8'h80, frame_length: 16'd16, id_match: 1'b1};

   typedef struct packed {
      req_type req;
      logic    typed;   // 1: compare against want, else against the predictor
      rsp_type want;
   } table_row_type;

   // DUT ports; the inputs are known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [63:0] csr_wr_data = '0;

   // Shadow of the device and its configuration
   logic [63:0] device_id;
   logic [15:0] frame_pos;
   logic [7:0]  frame_sum;
   logic [15:0] frame_len_field;
   logic [7:0]  frame_format;
   logic [7:0]  frame_func;
   logic        frame_id_ok;
   logic        frame_saturated;

   rsp_type     results_due[$];   // expected responses, oldest first
   req_type     frame_bytes[$];   // next generated frame
   int          requests_sent  = 0;
   int          responses_seen = 0;
   int          fail_count     = 0;
   int          idle_cycles    = 0;

   // Receiver pacing
   int          stall_left   = 0;
   int          calm_left    = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 1'b0;
   int          roll;

   always #6 clock = ~clock;

   command_frame_checker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void restart_frame();
      frame_pos       = '0;
      frame_sum       = '0;
      frame_len_field = '0;
      frame_format    = '0;
      frame_func      = '0;
      frame_id_ok     = 1'b1;
      frame_saturated = 1'b0;
   endfunction

   // Applies one accepted request to the shadow state; emits tells whether
   // the request produces a response, out holds it.
   function automatic void advance_frame(input req_type r, output bit emits,
                                         output rsp_type out);
      logic [16:0] actual;
      status_type  status;
      int          shift;
      out   = '0;
      emits = 1'b0;
      if (r.last_byte) begin
         // Length problems win over the checksum; short and saturated frames
         // always count as length problems.
         actual = {1'b0, frame_pos} + 17'd1;
         if (frame_saturated || actual < MIN_FRAME_LEN || actual != {1'b0, frame_len_field}) begin
            status = STATUS_LENGTH;
         end else if (frame_sum != r.rx_byte) begin
            status = STATUS_CHECKSUM;
         end else begin
            status = STATUS_OK;
         end
         out.item_kind    = KIND_STATUS;
         out.frame_status = status;
         out.fmt_byte     = frame_format;
         out.cmd_byte     = frame_func;
         out.frame_length = frame_len_field;
         out.id_match     = frame_id_ok;
         emits = 1'b1;
         restart_frame();
      end else if (!frame_saturated) begin
         // Past the count ceiling non-final bytes are dropped without a trace
         frame_sum = frame_sum + r.rx_byte;
         if (frame_pos == LEN_HI_POS) begin
            frame_len_field[15:8] = r.rx_byte;
         end else if (frame_pos == LEN_LO_POS) begin
            frame_len_field[7:0] = r.rx_byte;
         end else if (frame_pos == FORMAT_POS) begin
            frame_format = r.rx_byte;
         end else if (frame_pos >= ID_FIRST && frame_pos <= ID_LAST) begin
            // byte 5 against bits 63:56, down to byte 12 against bits 7:0
            shift = 8 * int'(ID_LAST - frame_pos);
            if (8'(device_id >> shift) != r.rx_byte) begin
               frame_id_ok = 1'b0;
            end
         end else if (frame_pos == FUNC_POS) begin
            frame_func = r.rx_byte;
         end
         if (frame_pos > FUNC_POS) begin
            emits         = 1'b1;
            out.item_kind = KIND_ARG;
            out.arg_byte  = r.rx_byte;
            out.arg_index = frame_pos - ARG_FIRST;
         end
         if (frame_pos == COUNT_MAX) begin
            frame_saturated = 1'b1;
         end else begin
            frame_pos = frame_pos + 16'd1;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_response(input rsp_type got);
      rsp_type want;
      if (results_due.size() == 0) begin
         $error("response with nothing expected: 0x%0h", got);
         fail_count++;
      end else begin
         want = results_due.pop_front();
         compare_field("item_kind", 16'(want.item_kind), 16'(got.item_kind));
         compare_field("arg_byte", 16'(want.arg_byte), 16'(got.arg_byte));
         compare_field("arg_index", want.arg_index, got.arg_index);
         compare_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
         compare_field("fmt_byte", 16'(want.fmt_byte), 16'(got.fmt_byte));
         compare_field("cmd_byte", 16'(want.cmd_byte), 16'(got.cmd_byte));
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("id_match", 16'(want.id_match), 16'(got.id_match));
      end
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: checks every accepted response and paces rsp_stall. One long
   // hold-off, once enough responses have gone by, lets the sender fill the
   // block until req_stall rises.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         check_response(rsp_data);
         responses_seen++;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
      end else if (!holdoff_done && responses_seen >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (calm_left > 0) begin
         calm_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            calm_left = $urandom_range(30, 150);   // stretch with no stall
         end else if (roll < 40) begin
            stall_left = pick_gap();
         end
      end
      rsp_stall <= (holdoff_left > 0) || (stall_left > 0);
   end

   // Watchdog: ends the run if no handshake happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Offers one request after an idle gap given by gap and holds it until accepted.
   // typed selects a hand-written expectation over the predicted one; the
   // predictor still runs so the shadow state follows the frame.
   task automatic offer_request(input req_type r, input int gap, input bit typed,
                                input rsp_type typed_rsp);
      bit      emits;
      rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_frame(r, emits, predicted);
      if (typed) begin
         results_due.push_back(typed_rsp);
      end else if (emits) begin
         results_due.push_back(predicted);
      end
      requests_sent++;
   endtask

   // Sender stops until every response is in, then lets the last silent
   // requests leave the pipeline.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_device_id(input logic [63:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      device_id    = value;
   endtask

   // Directed rows: a lone final byte straight after reset, a well-formed
   // 16-byte frame with one argument at the byte extremes, and a short frame
   // that still captures length, format and a mismatching ID.
   task automatic run_directed();
      table_row_type rows[25];
      rows = '{
         '{'{8'hFF, 1'b1}, 1'b1, SHORT_AFTER_RESET},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'hFF, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h10, 1'b0}, 1'b0, '0},
         '{'{8'hFF, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0}, 1'b0, '0},
         '{'{8'h80, 1'b0}, 1'b0, '0},
         '{'{8'hFF, 1'b0}, 1'b1, FIRST_ARG_FF},
         '{'{8'h8D, 1'b1}, 1'b1, GOOD_FRAME_16},
         '{'{8'h12, 1'b0}, 1'b0, '0},
         '{'{8'h34, 1'b0}, 1'b0, '0},
         '{'{8'hFF, 1'b0}, 1'b0, '0},
         '{'{8'hFF, 1'b0}, 1'b0, '0},
         '{'{8'h5A, 1'b0}, 1'b0, '0},
         '{'{8'h01, 1'b0}, 1'b0, '0},
         '{'{8'h80, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b1}, 1'b0, '0}
      };
      foreach (rows[i]) begin
         offer_request(rows[i].req, pick_gap(), rows[i].typed, rows[i].want);
      end
   endtask

   // Fills frame_bytes with one frame. Half are well formed with random
   // content and the current ID; the rest carry a wrong length, a wrong ID
   // byte, a wrong checksum, come up short, or are plain noise.
   task automatic build_random_frame();
      int          pick;
      int          nargs;
      int          actual;
      int          i;
      int          bad_id_pos;
      logic [15:0] declared;
      logic [7:0]  sum;
      logic [7:0]  b;
      frame_bytes.delete();
      pick = $urandom_range(0, 99);
      sum  = '0;
      if (pick < 8) begin
         // noise with stray end flags; the tail always closes the frame
         actual = $urandom_range(1, 40);
         for (i = 0; i < actual; i++) begin
            frame_bytes.push_back('{rx_byte: 8'($urandom),
               last_byte: (i == actual - 1) || ($urandom_range(0, 7) == 0)});
         end
      end else if (pick < 16) begin
         // short frame, under the minimum length
         actual = $urandom_range(1, 14);
         for (i = 0; i < actual; i++) begin
            frame_bytes.push_back('{rx_byte: 8'($urandom), last_byte: i == actual - 1});
         end
      end else begin
         nargs    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 48);
         actual   = 15 + nargs;
         declared = 16'(actual);
         if (pick < 28) begin
            case ($urandom_range(0, 2))
               0: declared = 16'(actual + $urandom_range(1, 3));
               1: declared = 16'(actual - 1);
               default: declared = 16'($urandom);
            endcase
         end
         bad_id_pos = (pick >= 28 && pick < 38) ?
                      $urandom_range(int'(ID_FIRST), int'(ID_LAST)) : -1;
         for (i = 0; i < actual - 1; i++) begin
            if (i == LEN_HI_POS) begin
               b = declared[15:8];
            end else if (i == LEN_LO_POS) begin
               b = declared[7:0];
            end else if (i >= ID_FIRST && i <= ID_LAST) begin
               b = 8'(device_id >> (8 * (int'(ID_LAST) - i)));
               if (i == bad_id_pos) begin
                  b = b ^ 8'($urandom_range(1, 255));
               end
            end else begin
               b = 8'($urandom);
            end
            sum = sum + b;
            frame_bytes.push_back('{rx_byte: b, last_byte: 1'b0});
         end
         if (pick >= 38 && pick < 50) begin
            sum = sum ^ 8'($urandom_range(1, 255));
         end
         frame_bytes.push_back('{rx_byte: sum, last_byte: 1'b1});
      end
   endtask

   task automatic run_random_phase(input bit pause_midway);
      int start;
      bit steady;
      bit paused;
      start  = requests_sent;
      paused = 1'b0;
      while (requests_sent - start < PHASE_ITEMS) begin
         build_random_frame();
         steady = ($urandom_range(0, 3) == 0);   // some frames go back to back
         foreach (frame_bytes[i]) begin
            offer_request(frame_bytes[i], steady ? 0 : pick_gap(), 1'b0, '0);
         end
         if (pause_midway && !paused && requests_sent - start > PHASE_ITEMS / 2) begin
            wait_until_drained();
            paused = 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [63:0] id_setting;
      device_id = '0;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the ID at its reset value of zero
      run_directed();

      // Random phases under different IDs: all ones, random, zero, random.
      // The ID only changes with the pipeline empty.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: id_setting = '1;
            2: id_setting = '0;
            default: id_setting = {$urandom, $urandom};
         endcase
         wait_until_drained();
         write_device_id(id_setting);
         run_random_phase(phase == 1);
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d expected responses never arrived", results_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== command_frame_checker_core.f =====
+incdir+hdl
hdl/cfc_pkg.sv
hdl/cfc_frame_tracker.sv
hdl/cfc_rsp_stage.sv
hdl/command_frame_checker_core.sv
test/testbench.sv
